FILE: rtl/rgma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgma_pkg: shared definitions for the ramped gain mix-accumulate block
// Fixed-point constants, configuration register indexes and the pipeline
// control bundle passed from the top level to the datapath.
// ----------------------------------------------------------------------------
package rgma_pkg;

  // Default width of the running gain.
  localparam int GAIN_BITS_DEFAULT = 32;

  localparam int SAMPLE_W = 32;

  // Fraction bits of the two fixed-point formats.
  localparam int Q_LO_FRAC = 15;
  localparam int Q_HI_FRAC = 23;

  // Product bits needed to form the result in the wider fraction format.
  localparam int SUM_W = SAMPLE_W + Q_HI_FRAC;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_VOLUME   = 2'd0,
    CFG_RAMP_STEP      = 2'd1,
    CFG_PRECISION_MODE = 2'd2
  } cfg_index_t;

  // Precision mode codes.
  localparam logic PREC_Q15 = 1'b0;
  localparam logic PREC_Q23 = 1'b1;

  // Load strobes for the two datapath stages after the input register.
  typedef struct packed {
    logic load_prod;
    logic load_result;
  } rgma_pipe_ctrl_t;

endpackage

FILE: rtl/ramped_gain_mix_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_gain_mix_accumulate: ramped gain mix into an accumulation buffer
// Scales each source sample by a running fixed-point gain, adds it to the
// destination sample and steps the gain by a ramp after every sample.
// ----------------------------------------------------------------------------
// Pipeline: a request accepted at a clock edge passes through the input,
// partial-product and result registers on its way to the result ports.
// Throughput: one request per cycle. A stalled result holds back only the full
// stages behind it; empty stages keep filling, so bubbles are squeezed out.
// Reset: clears the configuration registers, the running gain and all stage
// valid bits; the first request after reset starts a new block.
// ----------------------------------------------------------------------------
module ramped_gain_mix_accumulate
  import rgma_pkg::*;
#(
  parameter int GAIN_BITS = GAIN_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,

  // Configuration write port.
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  // Sample requests.
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic signed [31:0]     in_sample,
  input  logic signed [31:0]     acc_sample,
  input  logic                   last,

  // Result requests.
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic signed [31:0]     mixed_sample,
  output logic signed [31:0]     tail_sample,
  output logic                   end_of_block
);

  // Configuration registers.
  logic signed [31:0] start_volume;
  logic signed [31:0] ramp_step;
  logic               precision_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_volume   <= '0;
      ramp_step      <= '0;
      precision_mode <= PREC_Q15;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_VOLUME:   start_volume   <= $signed(cfg_data);
        CFG_RAMP_STEP:      ramp_step      <= $signed(cfg_data);
        CFG_PRECISION_MODE: precision_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage takes new data when it is empty or
  // when the stage after it is moving. The stall reaching the sample side
  // is the result-side stall propagated back through full stages only.
  logic v_in;
  logic v_prod;
  logic v_result;
  logic ready_in;
  logic ready_prod;
  logic ready_result;
  logic accept;

  assign ready_result = !v_result || !result_stall;
  assign ready_prod   = !v_prod   || ready_result;
  assign ready_in     = !v_in     || ready_prod;
  assign sample_stall = !ready_in;
  assign accept       = sample_valid && ready_in;
  assign result_valid = v_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in     <= 1'b0;
      v_prod   <= 1'b0;
      v_result <= 1'b0;
    end else begin
      if (ready_in) begin
        v_in <= sample_valid;
      end
      if (ready_prod) begin
        v_prod <= v_in;
      end
      if (ready_result) begin
        v_result <= v_prod;
      end
    end
  end

  // The gain is sampled at acceptance so the ramp advances once per request,
  // independent of how long the request later sits in the pipeline.
  logic signed [GAIN_BITS-1:0] gain;

  rgma_gain #(
    .GAIN_BITS (GAIN_BITS)
  ) u_gain (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .last         (last),
    .start_volume (start_volume),
    .ramp_step    (ramp_step),
    .gain         (gain)
  );

  // Input register: the request together with the gain that applies to it.
  logic signed [31:0]          in_x;
  logic signed [31:0]          in_acc;
  logic                        in_last;
  logic signed [GAIN_BITS-1:0] in_gain;
  logic                        in_prec;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_x    <= in_sample;
      in_acc  <= acc_sample;
      in_last <= last;
      in_gain <= gain;
      in_prec <= precision_mode;
    end
  end

  rgma_pipe_ctrl_t ctrl;

  assign ctrl = '{load_prod: v_in && ready_prod, load_result: v_prod && ready_result};

  rgma_mac #(
    .GAIN_BITS (GAIN_BITS)
  ) u_mac (
    .clk          (clk),
    .ctrl         (ctrl),
    .x            (in_x),
    .acc          (in_acc),
    .last         (in_last),
    .gain         (in_gain),
    .prec         (in_prec),
    .mixed_sample (mixed_sample),
    .tail_sample  (tail_sample),
    .end_of_block (end_of_block)
  );

endmodule

FILE: rtl/rgma_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgma_gain: running gain sequencer
// Supplies the gain for the sample being accepted and steps it by the ramp,
// reloading from the start volume at the first sample of each block.
// ----------------------------------------------------------------------------
module rgma_gain
  import rgma_pkg::*;
#(
  parameter int GAIN_BITS = GAIN_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        last,
  input  logic signed [31:0]          start_volume,
  input  logic signed [31:0]          ramp_step,
  output logic signed [GAIN_BITS-1:0] gain
);

  logic signed [GAIN_BITS-1:0] current_gain;
  logic                        at_block_start;
  logic signed [GAIN_BITS-1:0] start_ext;
  logic signed [GAIN_BITS-1:0] ramp_ext;

  // Sign extend, or wrap when the gain is narrower than 32 bits.
  assign start_ext = GAIN_BITS'(start_volume);
  assign ramp_ext  = GAIN_BITS'(ramp_step);

  assign gain = at_block_start ? start_ext : current_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_gain   <= '0;
      at_block_start <= 1'b1;
    end else if (advance) begin
      current_gain   <= gain + ramp_ext;
      at_block_start <= last;
    end
  end

endmodule

FILE: rtl/rgma_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgma_mac: scaled multiply-accumulate datapath
// Forms two registered partial products of sample and gain, then sums them,
// picks the integer part for the fraction format and adds the destination.
// ----------------------------------------------------------------------------
module rgma_mac
  import rgma_pkg::*;
#(
  parameter int GAIN_BITS = GAIN_BITS_DEFAULT
) (
  input  logic                        clk,
  input  rgma_pipe_ctrl_t             ctrl,
  input  logic signed [31:0]          x,
  input  logic signed [31:0]          acc,
  input  logic                        last,
  input  logic signed [GAIN_BITS-1:0] gain,
  input  logic                        prec,
  output logic signed [31:0]          mixed_sample,
  output logic signed [31:0]          tail_sample,
  output logic                        end_of_block
);

  localparam int HI_BITS = GAIN_BITS / 2;
  localparam int LO_BITS = GAIN_BITS - HI_BITS;
  localparam int PP_LO_W = SAMPLE_W + LO_BITS + 1;
  localparam int PP_HI_W = SAMPLE_W + HI_BITS;

  logic signed [PP_LO_W-1:0] pp_lo_calc;
  logic signed [PP_HI_W-1:0] pp_hi_calc;

  logic signed [PP_LO_W-1:0] pp_lo;
  logic signed [PP_HI_W-1:0] pp_hi;
  logic signed [31:0]        acc_d;
  logic                      last_d;
  logic                      prec_d;

  logic [SUM_W-1:0] prod;
  logic [31:0]      scaled;

  // The low gain half is unsigned, the high half carries the sign.
  assign pp_lo_calc = x * $signed({1'b0, gain[LO_BITS-1:0]});
  assign pp_hi_calc = x * $signed(gain[GAIN_BITS-1:LO_BITS]);

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      pp_lo  <= pp_lo_calc;
      pp_hi  <= pp_hi_calc;
      acc_d  <= acc;
      last_d <= last;
      prec_d <= prec;
    end
  end

  // Product kept modulo 2^SUM_W, enough for the highest bit either format uses.
  assign prod = SUM_W'(pp_lo) + (SUM_W'(pp_hi) << LO_BITS);

  always_comb begin
    case (prec_d)
      PREC_Q15: scaled = prod[Q_LO_FRAC +: 32];
      PREC_Q23: scaled = prod[Q_HI_FRAC +: 32];
      default:  scaled = prod[Q_LO_FRAC +: 32];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_result) begin
      mixed_sample <= acc_d + $signed(scaled);
      tail_sample  <= last_d ? $signed(scaled) : '0;
      end_of_block <= last_d;
    end
  end

endmodule

FILE: test/tb_ramped_gain_mix_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ramped_gain_mix_accumulate: self-checking bench for the ramped gain mixer
// The bench streams sample requests through the block while the sender pauses
// in bursts and the receiver stalls at random. A predictor tracks the running
// gain and the configuration, and each result is checked field by field. The
// run covers directed corner cases first and then randomly configured phases.
// ----------------------------------------------------------------------------
module tb_ramped_gain_mix_accumulate;
  import rgma_pkg::*;

  // The predictor holds the gain at the width of the default build.
  localparam int GAIN_W       = GAIN_BITS_DEFAULT;
  // An accepted request passes the input, partial-product and result
  // registers before it can be taken as a result.
  localparam int PIPE_LATENCY = 3;
  // Far above the slowest legal run: about 2000 requests, each worst case
  // waiting out a sender gap and a long heavy-stall stretch.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQS    = 250;

  typedef struct packed {
    logic signed [31:0] in_sample;
    logic signed [31:0] acc_sample;
    logic               last;
  } sample_req_t;

  typedef struct packed {
    logic signed [31:0] mixed;
    logic signed [31:0] tail;
    logic               end_flag;
  } mix_result_t;

  // Receiver stall behaviors; one of them is picked every so often.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_style_t;

  // Clock, reset and every input of the block start at known values.
  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic signed [31:0]     in_sample    = '0;
  logic signed [31:0]     acc_sample   = '0;
  logic                   last         = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic signed [31:0]     mixed_sample;
  logic signed [31:0]     tail_sample;
  logic                   end_of_block;

  // Requests waiting to be driven, and results the block still owes.
  sample_req_t pending_q[$];
  mix_result_t mix_expect_q[$];

  // Predictor copy of the configuration and of the gain state.
  logic [31:0]       start_volume_reg = '0;
  logic [31:0]       ramp_step_reg    = '0;
  logic              precision_reg    = PREC_Q15;
  logic [GAIN_W-1:0] gain_now         = '0;
  logic              block_open       = 1'b1;

  bit           failed      = 1'b0;
  int           cycle_count = 0;
  int           burst_left  = 8;
  int           gap_left    = 0;
  int           stall_tick  = 0;
  stall_style_t stall_style = STALL_NONE;
  sample_req_t  next_req;
  mix_result_t  got;
  mix_result_t  want;

  ramped_gain_mix_accumulate dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .in_sample    (in_sample),
    .acc_sample   (acc_sample),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mixed_sample (mixed_sample),
    .tail_sample  (tail_sample),
    .end_of_block (end_of_block)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Works out the result of one accepted request and steps the gain. The
  // product is kept modulo 2^64, the accumulator is lifted into the same
  // fixed-point format, and the sum is floored back by the fraction width.
  function automatic mix_result_t apply_gain(input sample_req_t req);
    int          frac;
    logic [63:0] prod;
    logic [63:0] sum;
    mix_result_t res;
    frac = (precision_reg == PREC_Q23) ? Q_HI_FRAC : Q_LO_FRAC;
    if (block_open) begin
      gain_now = GAIN_W'($signed(start_volume_reg));
    end
    block_open = 1'b0;
    prod = 64'($signed(req.in_sample)) * 64'($signed(gain_now));
    sum  = ({32'b0, req.acc_sample} << frac) + prod;
    res.mixed    = sum[frac +: 32];
    res.tail     = req.last ? prod[frac +: 32] : 32'sd0;
    res.end_flag = req.last;
    // The ramp applies after every sample; a block end rearms the reload.
    gain_now = gain_now + GAIN_W'($signed(ramp_step_reg));
    if (req.last) begin
      block_open = 1'b1;
    end
    return res;
  endfunction

  // Sender. A request is taken at an edge where valid is high and stall is
  // low; the predictor sees it right there, with the payload still in place.
  // A stalled request holds its payload. Otherwise the sender either sits in
  // a gap or pulls the next request from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        mix_expect_q.push_back(apply_gain('{in_sample, acc_sample, last}));
      end
      if (sample_valid && sample_stall) begin
        sample_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        next_req = pending_q.pop_front();
        sample_valid <= 1'b1;
        in_sample    <= next_req.in_sample;
        acc_sample   <= next_req.acc_sample;
        last         <= next_req.last;
        burst_left--;
        if (burst_left <= 0) begin
          // Now and then a long burst with no gap, otherwise short bursts
          // that are mostly separated by short gaps.
          if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(100, 200);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Receiver. Each accepted result is matched against the oldest expected
  // one. The stall style is redrawn periodically so that stalls hit every
  // stage of the pipeline, with calm stretches in between.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got = '{mixed_sample, tail_sample, end_of_block};
        if (mix_expect_q.size() == 0) begin
          $display("%0t: result with no request outstanding: mixed %h tail %h end %b",
                   $time, got.mixed, got.tail, got.end_flag);
          failed = 1'b1;
        end else begin
          want = mix_expect_q.pop_front();
          if (got.mixed !== want.mixed) begin
            $display("%0t: mixed_sample expected %h actual %h",
                     $time, want.mixed, got.mixed);
            failed = 1'b1;
          end
          if (got.tail !== want.tail) begin
            $display("%0t: tail_sample expected %h actual %h",
                     $time, want.tail, got.tail);
            failed = 1'b1;
          end
          if (got.end_flag !== want.end_flag) begin
            $display("%0t: end_of_block expected %b actual %b",
                     $time, want.end_flag, got.end_flag);
            failed = 1'b1;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 200 == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
      end
      case (stall_style)
        STALL_NONE:      result_stall <= 1'b0;
        STALL_LIGHT:     result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:     result_stall <= ($urandom_range(0, 3) != 0);
        STALL_ALTERNATE: result_stall <= stall_tick[0];
        default:         result_stall <= 1'b0;
      endcase
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ramped_gain_mix_accumulate failed");
      $finish;
    end
  end

  task automatic queue_req(input logic [31:0] x, input logic [31:0] acc, input logic lst);
    pending_q.push_back('{x, acc, lst});
  endtask

  // Register writes go out only while the block is idle, so the predictor
  // copy can be updated on the spot.
  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_START_VOLUME:   start_volume_reg = value;
      CFG_RAMP_STEP:      ramp_step_reg    = value;
      CFG_PRECISION_MODE: precision_reg    = value[0];
      default:            ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every queued request is taken and every result is back, then
  // lets the pipeline settle for its latency.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_q.size() > 0 || sample_valid || mix_expect_q.size() > 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    if ($urandom_range(0, 1) == 0) begin
      return $urandom;
    end
    return 32'($urandom_range(0, 131071)) - 32'd65536;
  endfunction

  initial begin
    int          frac;
    int          block_left;
    logic [31:0] unity;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers at reset: zero start volume and zero ramp leave the gain at
    // zero, so the destination sample comes back untouched and the tail is 0.
    queue_req(32'h7fffffff, 32'h80000000, 1'b0);
    queue_req(32'h80000000, 32'h7fffffff, 1'b0);
    queue_req(32'hffffffff, 32'hffffffff, 1'b0);
    queue_req(32'h00000001, 32'h00000000, 1'b1);
    drain();

    // Most positive start with the most negative ramp in the wide format:
    // the gain wraps past the most negative value within the block, and
    // extreme samples give the largest products.
    write_reg(CFG_START_VOLUME, 32'h7fffffff);
    write_reg(CFG_RAMP_STEP, 32'h80000000);
    write_reg(CFG_PRECISION_MODE, 32'(PREC_Q23));
    queue_req(32'h80000000, 32'h00000000, 1'b0);
    queue_req(32'h7fffffff, 32'h7fffffff, 1'b0);
    queue_req(32'h80000000, 32'h80000000, 1'b0);
    queue_req(32'h7fffffff, 32'hffffffff, 1'b1);
    // A fresh block left open on purpose for the next phase.
    queue_req(32'd12345, 32'd7, 1'b0);
    drain();

    // Writes inside an open block: precision applies to the next sample, ramp
    // to the step after it, the start volume only once the block has ended.
    write_reg(CFG_START_VOLUME, 32'h80000000);
    write_reg(CFG_RAMP_STEP, 32'h7fffffff);
    write_reg(CFG_PRECISION_MODE, 32'(PREC_Q15));
    queue_req(32'h80000000, 32'h80000000, 1'b0);
    queue_req(32'h7fffffff, 32'h00000000, 1'b1);
    queue_req(32'h80000000, 32'h7fffffff, 1'b1);
    queue_req(32'hfffffffd, 32'h00000005, 1'b1);
    drain();

    // Unity gain fading down slowly over a short block, negative samples
    // included so the floor shows in the result.
    write_reg(CFG_START_VOLUME, 32'h00008000);
    write_reg(CFG_RAMP_STEP, 32'hfffffc00);
    queue_req(32'd1000, 32'd3, 1'b0);
    queue_req(32'hfffffc18, 32'hfffffffd, 1'b0);
    queue_req(32'd7, 32'd0, 1'b0);
    queue_req(32'hfffffff9, 32'd100, 1'b0);
    queue_req(32'd32767, 32'h80000000, 1'b1);
    drain();

    // Random phases, each with its own configuration. Gains are often near
    // unity with gentle ramps, as in real mixing, with full-range values
    // mixed in. Blocks have random lengths; a phase may end mid-block.
    repeat (RANDOM_PHASES) begin
      write_reg(CFG_PRECISION_MODE, 32'($urandom_range(0, 1)));
      frac  = (precision_reg == PREC_Q23) ? Q_HI_FRAC : Q_LO_FRAC;
      unity = 32'd1 << frac;
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_START_VOLUME, $urandom);
        1:       write_reg(CFG_START_VOLUME, 32'd0);
        default: write_reg(CFG_START_VOLUME,
                           unity + 32'($urandom_range(0, 2 * unity)) - unity);
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_RAMP_STEP, $urandom);
        1:       write_reg(CFG_RAMP_STEP, 32'd0);
        default: write_reg(CFG_RAMP_STEP, 32'($urandom_range(0, 512)) - 32'd256);
      endcase
      @(negedge clk);
      block_left = $urandom_range(1, 48);
      repeat (PHASE_REQS) begin
        block_left--;
        queue_req(pick_sample(), pick_sample(), block_left == 0);
        if (block_left == 0) begin
          block_left = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 48);
        end
      end
      drain();
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (!failed && mix_expect_q.size() == 0) begin
      $display("tb_ramped_gain_mix_accumulate passed");
    end else begin
      $display("tb_ramped_gain_mix_accumulate failed");
    end
    $finish;
  end

endmodule
